### design/mt_pkg.sv
`default_nettype none
package mt_pkg;

    // twister geometry
    localparam int unsigned TW_N = 624;
    localparam int unsigned TW_M = 397;
    localparam int unsigned AW   = 10;

    // key buffer geometry
    localparam int unsigned KEY_MAX = 64;
    localparam int unsigned KAW     = $clog2(KEY_MAX);
    localparam int unsigned KCW     = $clog2(KEY_MAX + 1);

    localparam logic [AW-1:0] LAST_ADDR  = AW'(TW_N - 1);
    localparam logic [AW-1:0] IDX_FULL   = AW'(TW_N);
    localparam logic [AW-1:0] FAR_SPLIT  = AW'(TW_N - TW_M);
    localparam logic [AW-1:0] FAR_FWD    = AW'(TW_M);
    localparam logic [AW-1:0] FAR_BACK   = AW'(TW_N - TW_M);
    localparam logic [AW-1:0] STEPS_A    = AW'(TW_N);
    localparam logic [AW-1:0] STEPS_B    = AW'(TW_N - 1);
    localparam logic [AW-1:0] IDX_RESET  = AW'(TW_N + 1);

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] MUL_SEED     = 32'd1812433253;
    localparam logic [31:0] MUL_KEY_A    = 32'd1664525;
    localparam logic [31:0] MUL_KEY_B    = 32'd1566083941;
    localparam logic [31:0] SEED_KEY     = 32'd19650218;
    localparam logic [31:0] SEED_DEFAULT = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    // item modes
    localparam logic [1:0] MODE_SEED    = 2'd0;
    localparam logic [1:0] MODE_KEY     = 2'd1;
    localparam logic [1:0] MODE_PRODUCE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_SV_INIT, S_SV_RD, S_SV_WR,
        S_KA_SEED, S_KA_RD, S_KA_WR, S_KA_WRAP,
        S_KB_RD, S_KB_WR, S_KB_WRAP, S_KFIN,
        S_RG_LD, S_RG_CUR, S_RG_RD, S_RG_WR,
        S_OUT_RD, S_OUT_T
    } t_state;

    typedef enum logic [2:0] {
        W_SEED, W_SV, W_KA, W_KB, W_PREV, W_HIGH, W_TWIST
    } t_wsel;

    typedef enum logic [1:0] {
        M_SV, M_KA, M_KB
    } t_mulsel;

    typedef enum logic [1:0] {
        SD_VALUE, SD_DEFAULT, SD_KEY
    } t_seedsel;

    typedef enum logic [1:0] {
        AFT_IDLE, AFT_KEY, AFT_REGEN
    } t_after;

    typedef struct packed {
        logic            cap_value;
        logic            rd_en;
        logic [AW-1:0]   addr_a;
        logic [AW-1:0]   addr_b;
        logic            wr_en;
        logic [AW-1:0]   wr_addr;
        t_wsel           wsel;
        logic            mul_en;
        t_mulsel         mul_sel;
        t_seedsel        seed_sel;
        logic            cur_load;
        logic [KAW-1:0]  key_idx;
        logic            key_wr_en;
        logic [KAW-1:0]  key_wr_addr;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic [31:0] twist(input logic [31:0] cur,
                                          input logic [31:0] nxt,
                                          input logic [31:0] far);
        logic [31:0] y;
        y = (cur & TOP_BIT) | (nxt & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

### design/mt_in_if.sv
`default_nettype none
interface mt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] value;
    logic        last;

    modport source(output valid, output mode, output value, output last, input ready);
    modport sink(input valid, input mode, input value, input last, output ready);
endinterface
`default_nettype wire

### design/mt_out_if.sv
`default_nettype none
interface mt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source(output valid, output random_word, input ready);
    modport sink(input valid, input random_word, output ready);
endinterface
`default_nettype wire

### design/mt19937_random_generator_core.sv
// 32-bit Mersenne Twister word generator.
// Input channel i_req carries mode, value and last; a transaction is taken
// when valid and ready are high at a clock edge. Mode 0 seeds from value,
// mode 1 buffers a key word (up to 64) and, when last is set, runs the key
// initialisation; mode 2 returns one tempered word on o_rsp. Mode 3 is dropped.
// Items are handled one at a time; ready is high only while the sequencer idles.
// Produce: a registered state memory read, then tempering into the output
// register once it is free; the next item is taken only after that load.
// When the read index wraps, a produce first regenerates the whole state.
// Seeding runs a multiply, then an add and write, for each word.
// A produce with no prior seed seeds with 5489 first.
// Reset (synchronous, active low) marks the state unseeded, empties the key
// buffer count and drops any word in the output register; memories are not cleared.
// The output register holds a word while the receiver stalls; new seed or
// key items are still taken meanwhile, and a following produce waits there.
`default_nettype none
module mt19937_random_generator_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mt_in_if.sink     i_req,
    mt_out_if.source  o_rsp
);

    mt_pkg::t_cmd  w_cmd;
    mt_pkg::t_stat w_stat;

    mt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_mode  (i_req.mode),
        .i_last  (i_req.last),
        .o_ready (i_req.ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    mt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_value       (i_req.value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_random_word (o_rsp.random_word)
    );

endmodule
`default_nettype wire

### design/mt_ctrl.sv
`default_nettype none
module mt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_mode,
    input  wire logic          i_last,
    output logic               o_ready,
    output mt_pkg::t_cmd       o_cmd,
    input  wire mt_pkg::t_stat i_stat
);

    mt_pkg::t_state                 r_state, n_state;
    logic [mt_pkg::AW-1:0]          r_idx, n_idx;
    logic [mt_pkg::AW-1:0]          r_cnt, n_cnt;
    logic [mt_pkg::AW-1:0]          r_steps, n_steps;
    logic [mt_pkg::KAW-1:0]         r_b, n_b;
    logic [mt_pkg::KCW-1:0]         r_len, n_len;
    logic [mt_pkg::KCW-1:0]         r_kcount, n_kcount;
    mt_pkg::t_seedsel               r_seed_sel, n_seed_sel;
    mt_pkg::t_after                 r_after, n_after;

    logic                           w_accept;
    logic [mt_pkg::KCW-1:0]         w_kc_inc;
    logic [mt_pkg::KAW-1:0]         w_b_next;
    logic [mt_pkg::AW-1:0]          w_cnt_inc;

    assign w_accept  = i_valid && o_ready;
    assign w_kc_inc  = mt_pkg::KCW'(r_kcount + 1'b1);
    assign w_cnt_inc = mt_pkg::AW'(r_cnt + 1'b1);
    // key index wraps at the key length
    assign w_b_next  = (mt_pkg::KCW'({1'b0, r_b}) + 1'b1 >= r_len) ? '0
                                                                    : mt_pkg::KAW'(r_b + 1'b1);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mt_pkg::S_IDLE;
            r_idx      <= mt_pkg::IDX_RESET;
            r_kcount   <= '0;
            r_cnt      <= '0;
            r_steps    <= '0;
            r_b        <= '0;
            r_len      <= '0;
            r_seed_sel <= mt_pkg::SD_VALUE;
            r_after    <= mt_pkg::AFT_IDLE;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_kcount   <= n_kcount;
            r_cnt      <= n_cnt;
            r_steps    <= n_steps;
            r_b        <= n_b;
            r_len      <= n_len;
            r_seed_sel <= n_seed_sel;
            r_after    <= n_after;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_kcount   = r_kcount;
        n_cnt      = r_cnt;
        n_steps    = r_steps;
        n_b        = r_b;
        n_len      = r_len;
        n_seed_sel = r_seed_sel;
        n_after    = r_after;
        o_ready    = 1'b0;
        o_cmd      = '0;
        o_cmd.wsel     = mt_pkg::W_PREV;
        o_cmd.mul_sel  = mt_pkg::M_SV;
        o_cmd.seed_sel = r_seed_sel;
        o_cmd.key_idx  = r_b;

        unique case (r_state)
            mt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (w_accept) begin
                    priority if (i_mode == mt_pkg::MODE_SEED) begin
                        o_cmd.cap_value = 1'b1;
                        n_seed_sel = mt_pkg::SD_VALUE;
                        n_after    = mt_pkg::AFT_IDLE;
                        n_state    = mt_pkg::S_SV_INIT;
                    end else if (i_mode == mt_pkg::MODE_KEY) begin
                        if (r_kcount < mt_pkg::KCW'(mt_pkg::KEY_MAX)) begin
                            o_cmd.key_wr_en   = 1'b1;
                            o_cmd.key_wr_addr = r_kcount[mt_pkg::KAW-1:0];
                            n_kcount = w_kc_inc;
                        end
                        if (i_last) begin
                            n_len      = (n_kcount == '0) ? mt_pkg::KCW'(1) : n_kcount;
                            n_kcount   = '0;
                            n_seed_sel = mt_pkg::SD_KEY;
                            n_after    = mt_pkg::AFT_KEY;
                            n_state    = mt_pkg::S_SV_INIT;
                        end
                    end else if (i_mode == mt_pkg::MODE_PRODUCE) begin
                        priority if (r_idx < mt_pkg::IDX_FULL) begin
                            n_state = mt_pkg::S_OUT_RD;
                        end else if (r_idx == mt_pkg::IDX_FULL) begin
                            n_state = mt_pkg::S_RG_LD;
                        end else begin
                            n_seed_sel = mt_pkg::SD_DEFAULT;
                            n_after    = mt_pkg::AFT_REGEN;
                            n_state    = mt_pkg::S_SV_INIT;
                        end
                    end else begin
                        n_state = mt_pkg::S_IDLE;
                    end
                end
            end
            // seed from one value
            mt_pkg::S_SV_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wsel    = mt_pkg::W_SEED;
                n_cnt   = mt_pkg::AW'(1);
                n_state = mt_pkg::S_SV_RD;
            end
            mt_pkg::S_SV_RD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mt_pkg::M_SV;
                n_state = mt_pkg::S_SV_WR;
            end
            mt_pkg::S_SV_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_cnt;
                o_cmd.wsel    = mt_pkg::W_SV;
                n_cnt   = w_cnt_inc;
                n_state = mt_pkg::S_SV_RD;
                if (r_cnt == mt_pkg::LAST_ADDR) begin
                    n_idx = mt_pkg::IDX_FULL;
                    unique case (r_after)
                        mt_pkg::AFT_KEY: begin
                            n_cnt   = mt_pkg::AW'(1);
                            n_b     = '0;
                            n_steps = mt_pkg::STEPS_A;
                            n_state = mt_pkg::S_KA_SEED;
                        end
                        mt_pkg::AFT_REGEN: n_state = mt_pkg::S_RG_LD;
                        default:           n_state = mt_pkg::S_IDLE;
                    endcase
                end
            end
            // word 0 becomes the previous word for the first key step
            mt_pkg::S_KA_SEED: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wsel    = mt_pkg::W_SEED;
                n_state = mt_pkg::S_KA_RD;
            end
            // key mixing, first pass
            mt_pkg::S_KA_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.addr_a  = r_cnt;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mt_pkg::M_KA;
                n_state = mt_pkg::S_KA_WR;
            end
            mt_pkg::S_KA_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_cnt;
                o_cmd.wsel    = mt_pkg::W_KA;
                n_b     = w_b_next;
                n_steps = mt_pkg::AW'(r_steps - 1'b1);
                if (r_cnt == mt_pkg::LAST_ADDR) begin
                    n_cnt   = mt_pkg::AW'(1);
                    n_state = mt_pkg::S_KA_WRAP;
                end else begin
                    n_cnt = w_cnt_inc;
                    if (r_steps == mt_pkg::AW'(1)) begin
                        n_steps = mt_pkg::STEPS_B;
                        n_state = mt_pkg::S_KB_RD;
                    end else begin
                        n_state = mt_pkg::S_KA_RD;
                    end
                end
            end
            mt_pkg::S_KA_WRAP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wsel    = mt_pkg::W_PREV;
                if (r_steps == '0) begin
                    n_steps = mt_pkg::STEPS_B;
                    n_state = mt_pkg::S_KB_RD;
                end else begin
                    n_state = mt_pkg::S_KA_RD;
                end
            end
            // key mixing, second pass
            mt_pkg::S_KB_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.addr_a  = r_cnt;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mt_pkg::M_KB;
                n_state = mt_pkg::S_KB_WR;
            end
            mt_pkg::S_KB_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_cnt;
                o_cmd.wsel    = mt_pkg::W_KB;
                n_steps = mt_pkg::AW'(r_steps - 1'b1);
                if (r_cnt == mt_pkg::LAST_ADDR) begin
                    n_cnt   = mt_pkg::AW'(1);
                    n_state = mt_pkg::S_KB_WRAP;
                end else begin
                    n_cnt   = w_cnt_inc;
                    n_state = (r_steps == mt_pkg::AW'(1)) ? mt_pkg::S_KFIN : mt_pkg::S_KB_RD;
                end
            end
            mt_pkg::S_KB_WRAP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wsel    = mt_pkg::W_PREV;
                n_state = (r_steps == '0) ? mt_pkg::S_KFIN : mt_pkg::S_KB_RD;
            end
            mt_pkg::S_KFIN: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wsel    = mt_pkg::W_HIGH;
                n_idx   = mt_pkg::IDX_FULL;
                n_state = mt_pkg::S_IDLE;
            end
            // regenerate the whole state
            mt_pkg::S_RG_LD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr_a = '0;
                n_cnt   = '0;
                n_state = mt_pkg::S_RG_CUR;
            end
            mt_pkg::S_RG_CUR: begin
                o_cmd.cur_load = 1'b1;
                n_state = mt_pkg::S_RG_RD;
            end
            mt_pkg::S_RG_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr_a = (r_cnt == mt_pkg::LAST_ADDR) ? '0 : w_cnt_inc;
                o_cmd.addr_b = (r_cnt < mt_pkg::FAR_SPLIT)
                             ? mt_pkg::AW'(r_cnt + mt_pkg::FAR_FWD)
                             : mt_pkg::AW'(r_cnt - mt_pkg::FAR_BACK);
                n_state = mt_pkg::S_RG_WR;
            end
            mt_pkg::S_RG_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = r_cnt;
                o_cmd.wsel     = mt_pkg::W_TWIST;
                o_cmd.cur_load = 1'b1;
                n_cnt = w_cnt_inc;
                if (r_cnt == mt_pkg::LAST_ADDR) begin
                    n_idx   = '0;
                    n_state = mt_pkg::S_OUT_RD;
                end else begin
                    n_state = mt_pkg::S_RG_RD;
                end
            end
            // read and temper one word
            mt_pkg::S_OUT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr_a = r_idx;
                n_idx   = mt_pkg::AW'(r_idx + 1'b1);
                n_state = mt_pkg::S_OUT_T;
            end
            mt_pkg::S_OUT_T: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = mt_pkg::S_IDLE;
                end
            end
            default: n_state = mt_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### design/mt_dpath.sv
`default_nettype none
module mt_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mt_pkg::t_cmd  i_cmd,
    output mt_pkg::t_stat      o_stat,
    input  wire logic [31:0]   i_value,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [31:0]        o_random_word
);

    logic [31:0] r_mem [mt_pkg::TW_N];
    logic [31:0] r_key [mt_pkg::KEY_MAX];
    logic [31:0] r_rd_a, r_rd_b, r_key_rd;
    logic [31:0] r_prev, r_prod, r_cur, r_value;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] w_wdata, w_seed, w_mix, w_mul_k;
    logic        w_prev_load;

    assign w_mix = r_prev ^ (r_prev >> 30);

    // seed source
    always_comb begin
        unique case (i_cmd.seed_sel)
            mt_pkg::SD_DEFAULT: w_seed = mt_pkg::SEED_DEFAULT;
            mt_pkg::SD_KEY:     w_seed = mt_pkg::SEED_KEY;
            default:            w_seed = r_value;
        endcase
    end

    // multiplier constant
    always_comb begin
        unique case (i_cmd.mul_sel)
            mt_pkg::M_KA: w_mul_k = mt_pkg::MUL_KEY_A;
            mt_pkg::M_KB: w_mul_k = mt_pkg::MUL_KEY_B;
            default:      w_mul_k = mt_pkg::MUL_SEED;
        endcase
    end

    // write data select
    always_comb begin
        w_prev_load = 1'b0;
        unique case (i_cmd.wsel)
            mt_pkg::W_SEED: begin
                w_wdata     = w_seed;
                w_prev_load = 1'b1;
            end
            mt_pkg::W_SV: begin
                w_wdata     = r_prod + {22'd0, i_cmd.wr_addr};
                w_prev_load = 1'b1;
            end
            mt_pkg::W_KA: begin
                w_wdata     = (r_rd_a ^ r_prod) + r_key_rd + {26'd0, i_cmd.key_idx};
                w_prev_load = 1'b1;
            end
            mt_pkg::W_KB: begin
                w_wdata     = (r_rd_a ^ r_prod) - {22'd0, i_cmd.wr_addr};
                w_prev_load = 1'b1;
            end
            mt_pkg::W_HIGH:  w_wdata = mt_pkg::TOP_BIT;
            mt_pkg::W_TWIST: w_wdata = mt_pkg::twist(r_cur, r_rd_a, r_rd_b);
            default:         w_wdata = r_prev;
        endcase
    end

    // twister state memory, two read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[i_cmd.addr_a];
            r_rd_b <= r_mem[i_cmd.addr_b];
        end
    end

    // key buffer memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr_en) begin
            r_key[i_cmd.key_wr_addr] <= i_value;
        end
        r_key_rd <= r_key[i_cmd.key_idx];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_value) begin
            r_value <= i_value;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 32'(w_mix * w_mul_k);
        end
        if (i_cmd.wr_en && w_prev_load) begin
            r_prev <= w_wdata;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.out_load) begin
            r_out <= mt_pkg::temper(r_rd_a);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_random_word   = r_out;

endmodule
`default_nettype wire

### dv/tb_mt19937_scoreboard.sv
`timescale 1ns / 100ps
package tb_mt19937_sb_pkg;

    // predictor of the twister and queue of expected words
    class mt_word_scoreboard;
        bit [31:0] tw_state [624];
        int unsigned rd_idx;
        bit [31:0] key_words [64];
        int unsigned key_len;
        bit [31:0] expected_words [$];
        int unsigned fail_count;

        function new();
            rd_idx = 625;
            key_len = 0;
            fail_count = 0;
        endfunction

        function void seed_from(bit [31:0] s);
            bit [31:0] p;
            tw_state[0] = s;
            for (int n = 1; n < 624; n++) begin
                p = tw_state[n-1];
                tw_state[n] = 32'd1812433253 * (p ^ (p >> 30)) + n;
            end
            rd_idx = 624;
        endfunction

        function void seed_from_key(int unsigned len);
            int unsigned a, b, steps;
            bit [31:0] p;
            if (len == 0) len = 1;
            seed_from(32'd19650218);
            a = 1;
            b = 0;
            steps = (len > 624) ? len : 624;
            for (; steps > 0; steps--) begin
                p = tw_state[a-1];
                tw_state[a] = (tw_state[a] ^ ((p ^ (p >> 30)) * 32'd1664525))
                              + key_words[b % 64] + b;
                a++;
                b++;
                if (a >= 624) begin
                    tw_state[0] = tw_state[623];
                    a = 1;
                end
                if (b >= len) b = 0;
            end
            for (steps = 623; steps > 0; steps--) begin
                p = tw_state[a-1];
                tw_state[a] = (tw_state[a] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - a;
                a++;
                if (a >= 624) begin
                    tw_state[0] = tw_state[623];
                    a = 1;
                end
            end
            tw_state[0] = 32'h8000_0000;
            rd_idx = 624;
        endfunction

        function bit [31:0] twist_word(bit [31:0] c, bit [31:0] nx, bit [31:0] f);
            bit [31:0] y;
            y = (c & 32'h8000_0000) | (nx & 32'h7fff_ffff);
            return f ^ (y >> 1) ^ (y[0] ? 32'h9908_b0df : 32'd0);
        endfunction

        function bit [31:0] next_tempered();
            bit [31:0] y;
            if (rd_idx >= 624) begin
                if (rd_idx != 624) seed_from(32'd5489);
                for (int k = 0; k < 624; k++)
                    tw_state[k] = twist_word(tw_state[k], tw_state[(k+1) % 624],
                                             tw_state[(k+397) % 624]);
                rd_idx = 0;
            end
            y = tw_state[rd_idx];
            rd_idx++;
            y ^= (y >> 11);
            y ^= (y << 7) & 32'h9d2c_5680;
            y ^= (y << 15) & 32'hefc6_0000;
            y ^= (y >> 18);
            return y;
        endfunction

        // note one accepted input transaction
        function void note_request(bit [1:0] mode, bit [31:0] value, bit last);
            case (mode)
                mt_pkg::MODE_SEED: seed_from(value);
                mt_pkg::MODE_KEY: begin
                    if (key_len < 64) begin
                        key_words[key_len] = value;
                        key_len++;
                    end
                    if (last) begin
                        seed_from_key(key_len);
                        key_len = 0;
                    end
                end
                mt_pkg::MODE_PRODUCE: expected_words.push_back(next_tempered());
                default: ;
            endcase
        endfunction

        // check one accepted result transaction
        function void check_word(bit [31:0] got);
            bit [31:0] exp_word;
            if (expected_words.size() == 0) begin
                $error("random_word: unexpected result %h", got);
                fail_count++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (got !== exp_word) begin
                $error("random_word: expected %h actual %h", exp_word, got);
                fail_count++;
            end
        endfunction
    endclass

endpackage

### dv/tb_mt19937_random_generator_core.sv
`timescale 1ns / 100ps
module tb_mt19937_random_generator_core;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   no_idle = 1'b0;
    bit   hold_off = 1'b0;

    mt_in_if  req_if ();
    mt_out_if rsp_if ();

    mt19937_random_generator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    tb_mt19937_sb_pkg::mt_word_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    // send one transaction, with a random idle gap before it
    task automatic send_item(bit [1:0] mode, bit [31:0] value, bit last);
        while (!no_idle && $urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.value <= value;
        req_if.last <= last;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(mode, value, last);
    endtask

    task automatic send_key(int unsigned len);
        for (int k = 0; k < len; k++)
            send_item(mt_pkg::MODE_KEY, $urandom(), k == len - 1);
    endtask

    // receiver with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_word(rsp_if.random_word);
            rsp_if.ready <= !hold_off && (no_idle || $urandom_range(99) >= 17);
        end
    end

    // stimulus
    initial begin
        int unsigned r;
        req_if.valid = 1'b0;
        req_if.mode = mt_pkg::MODE_SEED;
        req_if.value = '0;
        req_if.last = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: produce before seeding, extremes, mode 3, overflow
        send_item(mt_pkg::MODE_PRODUCE, 32'hffff_ffff, 1'b1);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        send_item(mt_pkg::MODE_UNUSED, 32'hffff_ffff, 1'b1);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        send_item(mt_pkg::MODE_SEED, 32'h0, 1'b1);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        send_item(mt_pkg::MODE_SEED, 32'hffff_ffff, 1'b0);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b1);
        send_item(mt_pkg::MODE_KEY, 32'hffff_ffff, 1'b1);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        send_item(mt_pkg::MODE_KEY, 32'h0, 1'b0);
        send_item(mt_pkg::MODE_SEED, 32'd1234, 1'b0);
        send_item(mt_pkg::MODE_KEY, 32'h0, 1'b1);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        send_key(66);
        send_item(mt_pkg::MODE_PRODUCE, 32'h0, 1'b0);
        // long hold-off while produces keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (12) send_item(mt_pkg::MODE_PRODUCE, $urandom(), $urandom_range(1));
        join
        // one unbroken stretch of produces
        no_idle = 1'b1;
        repeat (200) send_item(mt_pkg::MODE_PRODUCE, $urandom(), 1'b0);
        no_idle = 1'b0;
        // random: mostly produces, some seeds, keys and noise
        for (int i = 0; i < 150; i++) begin
            r = $urandom_range(99);
            if (r < 80)
                send_item(mt_pkg::MODE_PRODUCE, $urandom(), $urandom_range(1));
            else if (r < 86)
                send_item(mt_pkg::MODE_SEED, $urandom(), $urandom_range(1));
            else if (r < 91)
                send_item(mt_pkg::MODE_KEY, $urandom(), $urandom_range(1));
            else if (r < 94)
                send_key($urandom_range(1, 8));
            else
                send_item(mt_pkg::MODE_UNUSED, $urandom(), $urandom_range(1));
        end
        req_if.valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
design/mt_pkg.sv
design/mt_in_if.sv
design/mt_out_if.sv
design/mt_ctrl.sv
design/mt_dpath.sv
design/mt19937_random_generator_core.sv
dv/tb_mt19937_scoreboard.sv
dv/tb_mt19937_random_generator_core.sv
